### sv/bvs_pkg.sv
// Package for the bounded vector store: shared types and the action and status codes.
// Has no dependencies. The memory, the controller, the top level and the checker import it.
package bvs_pkg;

    typedef logic signed [31:0] word_t;
    typedef logic [2:0]         action_t;
    typedef logic [1:0]         status_t;

    localparam action_t ACT_APPEND    = 3'd0;
    localparam action_t ACT_FIND      = 3'd1;
    localparam action_t ACT_OVERWRITE = 3'd2;
    localparam action_t ACT_READ      = 3'd3;
    localparam action_t ACT_REVERSE   = 3'd4;

    localparam status_t ST_OK       = 2'd0;
    localparam status_t ST_FULL     = 2'd1;
    localparam status_t ST_BADPOS   = 2'd2;
    localparam status_t ST_NOTFOUND = 2'd3;

endpackage

### sv/bvs_mem.sv
// Word memory for the bounded vector store: one write port and one read port.
// The read data is registered. Depends on bvs_pkg.
module bvs_mem
    import bvs_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  word_t                      wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output word_t                      rdata
);

    word_t ram_reg [DEPTH];
    word_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/bvs_ctrl.sv
// Sequencer of the bounded vector store: decodes each transaction and steps the
// shared memory port and word comparator through find, read and reverse. Depends on bvs_pkg.
module bvs_ctrl
    import bvs_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  action_t                    action,
    input  word_t                      value,
    input  logic [7:0]                 position,
    output logic                       done,
    output status_t                    status,
    output word_t                      data,
    output logic [7:0]                 found_index,
    output logic [8:0]                 count,
    output logic                       mem_we,
    output logic [$clog2(DEPTH)-1:0]   mem_waddr,
    output word_t                      mem_wdata,
    output logic                       mem_re,
    output logic [$clog2(DEPTH)-1:0]   mem_raddr,
    input  word_t                      mem_rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_FIND      = 3'd1;
    localparam logic [2:0] S_READ_ADDR = 3'd2;
    localparam logic [2:0] S_READ_DATA = 3'd3;
    localparam logic [2:0] S_REV_RLO   = 3'd4;
    localparam logic [2:0] S_REV_RHI   = 3'd5;
    localparam logic [2:0] S_REV_WLO   = 3'd6;
    localparam logic [2:0] S_REV_WHI   = 3'd7;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic          pend_reg, pend_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic          more_reg, more_next;
    word_t         value_reg, value_next;
    word_t         tmp_reg, tmp_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    word_t         data_reg, data_next;
    logic [7:0]    found_reg, found_next;

    logic          pos_ok;
    logic          issue;
    logic          more;

    assign pos_ok = PW'(position) < PW'(count_reg);
    assign issue  = scan_reg < count_reg;
    assign more   = ((AW + 1)'(lo_reg) + (AW + 1)'(2)) < (AW + 1)'(hi_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        scan_next     = scan_reg;
        pend_next     = pend_reg;
        pend_idx_next = pend_idx_reg;
        pos_next      = pos_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        more_next     = more_reg;
        value_next    = value_reg;
        tmp_next      = tmp_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        data_next     = data_reg;
        found_next    = found_reg;
        mem_we        = 1'b0;
        mem_waddr     = lo_reg;
        mem_wdata     = value;
        mem_re        = 1'b0;
        mem_raddr     = lo_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    data_next   = '0;
                    found_next  = '0;
                    unique case (action)
                        ACT_APPEND:
                        begin
                            done_next = 1'b1;
                            if (count_reg < CW'(DEPTH))
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        ACT_FIND:
                        begin
                            value_next = value;
                            scan_next  = '0;
                            pend_next  = 1'b0;
                            state_next = S_FIND;
                        end
                        ACT_OVERWRITE:
                        begin
                            done_next = 1'b1;
                            if (pos_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = AW'(position);
                            end
                            else
                            begin
                                status_next = ST_BADPOS;
                            end
                        end
                        ACT_READ:
                        begin
                            if (pos_ok)
                            begin
                                pos_next   = AW'(position);
                                state_next = S_READ_ADDR;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                status_next = ST_BADPOS;
                            end
                        end
                        ACT_REVERSE:
                        begin
                            if (count_reg >= CW'(2))
                            begin
                                lo_next    = '0;
                                hi_next    = AW'(count_reg - CW'(1));
                                state_next = S_REV_RLO;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                // One address goes out per cycle; the word read the cycle before is compared.
                mem_re    = issue;
                mem_raddr = AW'(scan_reg);
                if (pend_reg && (mem_rdata == value_reg))
                begin
                    done_next  = 1'b1;
                    found_next = 8'(pend_idx_reg);
                    state_next = S_IDLE;
                end
                else if (!issue && !pend_reg)
                begin
                    done_next   = 1'b1;
                    status_next = ST_NOTFOUND;
                    state_next  = S_IDLE;
                end
                else
                begin
                    if (issue)
                    begin
                        scan_next = scan_reg + CW'(1);
                    end
                    pend_next     = issue;
                    pend_idx_next = AW'(scan_reg);
                end
            end
            S_READ_ADDR:
            begin
                mem_re     = 1'b1;
                mem_raddr  = pos_reg;
                state_next = S_READ_DATA;
            end
            S_READ_DATA:
            begin
                done_next  = 1'b1;
                data_next  = mem_rdata;
                state_next = S_IDLE;
            end
            S_REV_RLO:
            begin
                mem_re     = 1'b1;
                mem_raddr  = lo_reg;
                state_next = S_REV_RHI;
            end
            S_REV_RHI:
            begin
                mem_re     = 1'b1;
                mem_raddr  = hi_reg;
                tmp_next   = mem_rdata;
                state_next = S_REV_WLO;
            end
            S_REV_WLO:
            begin
                // The low slot takes the high word while the next low word is fetched, if another pair remains.
                mem_we     = 1'b1;
                mem_waddr  = lo_reg;
                mem_wdata  = mem_rdata;
                more_next  = more;
                mem_re     = more;
                mem_raddr  = lo_reg + AW'(1);
                state_next = S_REV_WHI;
            end
            S_REV_WHI:
            begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = tmp_reg;
                if (more_reg)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = hi_reg - AW'(1);
                    tmp_next   = mem_rdata;
                    lo_next    = lo_reg + AW'(1);
                    hi_next    = hi_reg - AW'(1);
                    state_next = S_REV_WLO;
                end
                else
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
            more_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            pend_reg  <= pend_next;
            more_reg  <= more_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg     <= scan_next;
        pend_idx_reg <= pend_idx_next;
        pos_reg      <= pos_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        value_reg    <= value_next;
        tmp_reg      <= tmp_next;
        status_reg   <= status_next;
        data_reg     <= data_next;
        found_reg    <= found_next;
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign data        = data_reg;
    assign found_index = found_reg;
    assign count       = 9'(count_reg);

endmodule

### sv/bounded_vector_store.sv
// Top level of the bounded vector store: the sequencer and the word memory.
// Depends on bvs_pkg, bvs_ctrl and bvs_mem.
//
//   Channel   Handshake            Fields
//   command   start / busy         action, value, position
//   result    done (one cycle)     status, data, found_index, count
//
// Append, overwrite, failed reads, reverses of fewer than two words and unused actions give
// their result in the cycle after the transaction. A read passes through S_READ_ADDR and
// S_READ_DATA first. Find and reverse walk the stored words through the memory.
// Reset clears the count and the sequencer; the memory is not cleared.
// Results cannot be stalled: busy is low in the cycle that done is shown.
module bounded_vector_store
    import bvs_pkg::*;
#(
    parameter int DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  action_t     action,
    input  word_t       value,
    input  logic [7:0]  position,
    output logic        done,
    output status_t     status,
    output word_t       data,
    output logic [7:0]  found_index,
    output logic [8:0]  count
);

    localparam int AW = $clog2(DEPTH);

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    word_t         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    word_t         mem_rdata;

    bvs_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .value       (value),
        .position    (position),
        .done        (done),
        .status      (status),
        .data        (data),
        .found_index (found_index),
        .count       (count),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_re      (mem_re),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    bvs_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

### sv/bvs_checker.sv
// Port-level checks for the bounded vector store, bound to the top level.
// Depends on bvs_pkg and bounded_vector_store.
module bvs_checker
    import bvs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input action_t    action,
    input logic       done,
    input status_t    status,
    input word_t      data,
    input logic [8:0] count
);

    // A result is only shown while the block is free for the next transaction.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while busy");

    // Every accepted transaction either keeps the block busy or finishes at once.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy || done))
        else $error("accepted transaction neither busy nor finished");

    // Append and overwrite finish in the cycle after they are accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_APPEND || action == ACT_OVERWRITE)) |=> done)
        else $error("append or overwrite did not finish in one cycle");

    // Any failed action reports zero data.
    assert property (@(posedge clk) disable iff (!rst_n) (done && status != ST_OK) |-> data == '0)
        else $error("failed action returned data");

    // The count moves only after an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n) !(start && !busy) |=> $stable(count))
        else $error("count changed without a transaction");

endmodule

bind bounded_vector_store bvs_checker u_bvs_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .action (action),
    .done   (done),
    .status (status),
    .data   (data),
    .count  (count)
);
